// File: src/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types for the delta-list timer queue
// Request, result, list entry and per-cell command types.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int NSLOT    = 16;
  localparam int MAX_WAKE = 16;

  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_TICK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_ACTIVE   = 2'd2,
    ST_INACTIVE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  timer_slot;
    logic [31:0] expires_ticks;
    logic [11:0] proc_id;
  } req_t;

  typedef struct packed {
    logic        woke_valid;
    logic [11:0] woke_proc;
    logic [3:0]  woke_slot;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] delta;
    logic [11:0] proc;
    logic [3:0]  slot;
  } ent_t;

  typedef enum logic [2:0] {
    C_HOLD  = 3'd0,
    C_CLEAR = 3'd1,
    C_WALK  = 3'd2,
    C_INS   = 3'd3,
    C_DEL   = 3'd4,
    C_DEC   = 3'd5,
    C_POP   = 3'd6
  } cop_t;

  typedef struct packed {
    cop_t        op;
    logic        is_add;
    logic [31:0] rem;
    logic [3:0]  key;
    ent_t        nent;
  } cmd_t;

endpackage

// File: src/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell: one position of the ordered timer list
// Holds one entry, a walk token and a passed mark; shifts with its neighbors.
// ----------------------------------------------------------------------------
module dltq_cell (
  input  logic           clk,
  input  logic           rst,
  input  dltq_pkg::cmd_t cmd,
  input  logic           seed,
  input  dltq_pkg::ent_t left_ent,
  input  logic           left_passed,
  input  logic           left_first,
  input  logic           left_cont,
  input  dltq_pkg::ent_t right_ent,
  output dltq_pkg::ent_t ent,
  output logic           passed,
  output logic           first,
  output logic           cont,
  output logic           hit,
  output logic [31:0]    sel_delta
);
  import dltq_pkg::*;

  logic tok;
  logic stop;
  ent_t ins_ent;
  ent_t del_ent;

  always_comb begin
    if (cmd.is_add) begin
      stop = !ent.valid || (cmd.rem < ent.delta);
    end else begin
      stop = !ent.valid || (ent.slot == cmd.key);
    end
    hit       = tok & stop;
    cont      = tok & !stop;
    sel_delta = cont ? ent.delta : 32'd0;
    first     = !passed & left_passed;
    // Entry pushed behind a new one loses the new entry's delta.
    ins_ent       = left_ent;
    ins_ent.delta = left_ent.delta - cmd.rem;
    // Successor of a removed entry takes over its delta.
    del_ent       = right_ent;
    del_ent.delta = right_ent.delta + ent.delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      passed    <= 1'b0;
      tok       <= 1'b0;
    end else begin
      case (cmd.op)
        C_CLEAR: begin
          passed <= 1'b0;
          tok    <= seed;
        end
        C_WALK: begin
          passed <= passed | cont;
          tok    <= left_cont;
        end
        C_INS: begin
          tok <= 1'b0;
          if (first) begin
            ent <= cmd.nent;
          end else if (left_first) begin
            ent <= ins_ent;
          end else if (!passed) begin
            ent <= left_ent;
          end
        end
        C_DEL: begin
          tok <= 1'b0;
          if (first) begin
            ent <= del_ent;
          end else if (!passed) begin
            ent <= right_ent;
          end
        end
        C_DEC: begin
          if (seed && ent.valid && ent.delta != 32'd0) begin
            ent.delta <= ent.delta - 32'd1;
          end
        end
        C_POP: begin
          ent <= right_ent;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue: timer slots kept as an ordered delta list
// Top level: request decode, walk control and result generation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on req with start high; it is taken on a clock edge
//   where busy is low. busy stays high until the last result is out.
//   Results appear on res for exactly one cycle, marked by strobe; the
//   receiver cannot stall them, so sample every strobe.
//   The list lives in a row of NUM_TIMERS cells in expiry order; cell 0 is
//   the head. Each cell keeps its delta from the cell before it.
//   Add: a token walks down the row one cell per cycle, subtracting deltas,
//   then every cell behind the insertion point shifts right together.
//   Delete: the token walks to the matching slot, then cells shift left.
//   Add/delete walk the token, then shift; refused and undefined requests
//   skip both and go straight to their single result.
//   Tick decrements the head entry, then gives one result per woken
//   process, or one result when nothing expires (at most 16 per tick).
//   The walk length sets the add/delete latency.
//   Reset empties the list and marks all slots inactive.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dltq_pkg::req_t req,
  output logic           busy,
  output logic           strobe,
  output dltq_pkg::res_t res
);
  import dltq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_DONE  = 6'b001000,
    S_DEC   = 6'b010000,
    S_POP   = 6'b100000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic        is_add;
  logic [3:0]  key;
  logic [11:0] proc;
  logic [31:0] rem;
  logic [1:0]  status;
  logic [4:0]  cnt;
  logic [NUM_TIMERS-1:0] active;

  cmd_t cmd;
  ent_t cell_ent    [NUM_TIMERS];
  ent_t right_in    [NUM_TIMERS];
  ent_t left_in     [NUM_TIMERS];
  logic cell_passed [NUM_TIMERS];
  logic cell_first  [NUM_TIMERS];
  logic cell_cont   [NUM_TIMERS];
  logic cell_hit    [NUM_TIMERS];
  logic [31:0] cell_sel [NUM_TIMERS];

  logic        any_hit;
  logic        any_tok;
  logic [31:0] sel_or;
  logic        slot_ok;
  logic        pop_now;
  logic        pop_last;

  // Build the chain: neighbors hand entries and walk marks to each other.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = '0;
    end else begin : g_body
      assign left_in[i] = cell_ent[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign right_in[i] = '0;
    end else begin : g_mid
      assign right_in[i] = cell_ent[i+1];
    end
    dltq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .seed        (i == 0),
      .left_ent    (left_in[i]),
      .left_passed ((i == 0) ? 1'b1 : cell_passed[(i == 0) ? 0 : i-1]),
      .left_first  ((i == 0) ? 1'b0 : cell_first[(i == 0) ? 0 : i-1]),
      .left_cont   ((i == 0) ? 1'b0 : cell_cont[(i == 0) ? 0 : i-1]),
      .right_ent   (right_in[i]),
      .ent         (cell_ent[i]),
      .passed      (cell_passed[i]),
      .first       (cell_first[i]),
      .cont        (cell_cont[i]),
      .hit         (cell_hit[i]),
      .sel_delta   (cell_sel[i])
    );
  end

  // Collect the walk token's cell: at most one cell drives its delta.
  always_comb begin
    any_hit = 1'b0;
    any_tok = 1'b0;
    sel_or  = 32'd0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      any_hit = any_hit | cell_hit[i];
      any_tok = any_tok | cell_hit[i] | cell_cont[i];
      sel_or  = sel_or | cell_sel[i];
    end
  end

  assign slot_ok = (32'(req.timer_slot) < NUM_TIMERS);
  assign busy    = (state != S_IDLE);

  // Head pops while it has expired; the cap limits wakes per tick.
  assign pop_now  = cell_ent[0].valid && (cell_ent[0].delta == 32'd0) &&
                    (32'(cnt) < MAX_WAKE);
  assign pop_last = (32'(cnt) == MAX_WAKE - 1) ||
                    !(cell_ent[1].valid && cell_ent[1].delta == 32'd0);

  always_comb begin
    cmd.op          = C_HOLD;
    cmd.is_add      = is_add;
    cmd.rem         = rem;
    cmd.key         = key;
    cmd.nent.valid  = 1'b1;
    cmd.nent.delta  = rem;
    cmd.nent.proc   = proc;
    cmd.nent.slot   = key;
    state_next      = state;
    strobe          = 1'b0;
    res             = '0;
    case (state)
      S_IDLE: begin
        cmd.op = C_CLEAR;
        if (start) begin
          case (func_t'(req.func))
            FN_ADD: begin
              if (!slot_ok || req.expires_ticks == 32'd0 || active[req.timer_slot]) begin
                state_next = S_DONE;
              end else begin
                state_next = S_WALK;
              end
            end
            FN_DEL: begin
              if (!slot_ok || !active[req.timer_slot]) begin
                state_next = S_DONE;
              end else begin
                state_next = S_WALK;
              end
            end
            FN_TICK: state_next = S_DEC;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        cmd.op = C_WALK;
        if (any_hit || !any_tok) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.op     = is_add ? C_INS : C_DEL;
        state_next = S_DONE;
      end
      S_DONE: begin
        strobe     = 1'b1;
        res.status = status;
        res.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_DEC: begin
        cmd.op     = C_DEC;
        state_next = S_POP;
      end
      S_POP: begin
        strobe = 1'b1;
        if (pop_now) begin
          cmd.op         = C_POP;
          res.woke_valid = 1'b1;
          res.woke_proc  = cell_ent[0].proc;
          res.woke_slot  = cell_ent[0].slot;
          res.last       = pop_last;
          if (pop_last) begin
            state_next = S_IDLE;
          end
        end else begin
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            is_add <= (req.func == FN_ADD);
            key    <= req.timer_slot;
            proc   <= req.proc_id;
            rem    <= req.expires_ticks;
            cnt    <= 5'd0;
            status <= ST_OK;
            if (req.func == FN_ADD) begin
              if (!slot_ok) begin
                status <= ST_INACTIVE;
              end else if (req.expires_ticks == 32'd0) begin
                status <= ST_ZERO;
              end else if (active[req.timer_slot]) begin
                status <= ST_ACTIVE;
              end
            end else if (req.func == FN_DEL) begin
              if (!slot_ok || !active[req.timer_slot]) begin
                status <= ST_INACTIVE;
              end
            end
          end
        end
        S_WALK: begin
          // Advance the remaining tick count past each passed entry.
          if (is_add) begin
            rem <= rem - sel_or;
          end
        end
        S_SHIFT: begin
          active[key] <= is_add;
        end
        S_POP: begin
          if (pop_now) begin
            active[cell_ent[0].slot] <= 1'b0;
            cnt <= cnt + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: test/tb_delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// tb_delta_list_timer_queue: self-checking bench for the delta-list timer queue
// Drives add, delete, tick and no-op requests with random gaps, predicts every wake-up
// and status result from a local copy of the timer list, and compares them.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  localparam int NT        = 16;
  localparam int NIL       = NT;
  localparam int CYC_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic strobe;
  res_t res;

  delta_list_timer_queue #(.NUM_TIMERS(NT)) u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .strobe(strobe), .res(res)
  );

  // Local copy of the timer list, kept as a linked list of slots.
  logic        tm_active [NT];
  logic [31:0] tm_delta  [NT];
  logic [11:0] tm_proc   [NT];
  int          tm_next   [NT];
  int          tm_head;

  req_t pending_reqs[$];   // requests not yet offered to the block
  res_t wake_expect[$];    // results still owed by the block
  int   mismatches = 0;
  int   gap_left   = 0;
  bit   no_idle    = 0;    // phases without any gaps
  int   cycles     = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic res_t mk_res(logic v, logic [11:0] p, logic [3:0] s,
                                  status_t st, logic l);
    res_t r;
    r.woke_valid = v;
    r.woke_proc  = p;
    r.woke_slot  = s;
    r.status     = st;
    r.last       = l;
    return r;
  endfunction

  function automatic status_t list_insert(int s, logic [31:0] e, logic [11:0] p);
    int prv, cur, steps;
    prv = NIL;
    cur = tm_head;
    steps = 0;
    if (e == 0) return ST_ZERO;
    if (tm_active[s]) return ST_ACTIVE;
    // walk the list, spending the tick count on each earlier entry
    while (cur < NT && steps < NT) begin
      if (e < tm_delta[cur]) begin
        tm_delta[cur] -= e;
        break;
      end
      e -= tm_delta[cur];
      prv = cur;
      cur = tm_next[cur];
      steps++;
    end
    tm_active[s] = 1;
    tm_delta[s]  = e;
    tm_proc[s]   = p;
    tm_next[s]   = cur;
    if (prv == NIL) tm_head = s;
    else tm_next[prv] = s;
    return ST_OK;
  endfunction

  function automatic status_t list_remove(int s);
    int prv, cur, nxt;
    prv = NIL;
    cur = tm_head;
    if (!tm_active[s]) return ST_INACTIVE;
    while (cur < NT && cur != s) begin
      prv = cur;
      cur = tm_next[cur];
    end
    tm_active[s] = 0;
    if (cur != s) return ST_OK;
    nxt = tm_next[s];
    // hand the remaining delta to the successor
    if (nxt < NT) tm_delta[nxt] += tm_delta[s];
    if (prv == NIL) tm_head = nxt;
    else tm_next[prv] = nxt;
    tm_next[s] = NIL;
    return ST_OK;
  endfunction

  // Work out every result one accepted request causes.
  function automatic void predict_wakeups(req_t r);
    int n, h;
    res_t w;
    n = 0;
    case (func_t'(r.func))
      FN_ADD:
        wake_expect.push_back(mk_res(0, 0, 0,
          list_insert(r.timer_slot, r.expires_ticks, r.proc_id), 1));
      FN_DEL:
        wake_expect.push_back(mk_res(0, 0, 0, list_remove(r.timer_slot), 1));
      FN_NOP:
        wake_expect.push_back(mk_res(0, 0, 0, ST_OK, 1));
      default: begin
        // a head already at zero is popped without decrementing
        if (tm_head < NT && tm_delta[tm_head] != 0) tm_delta[tm_head]--;
        while (n < MAX_WAKE && tm_head < NT && tm_delta[tm_head] == 0) begin
          h = tm_head;
          wake_expect.push_back(mk_res(1, tm_proc[h], h[3:0], ST_OK, 0));
          n++;
          tm_active[h] = 0;
          tm_head = tm_next[h];
          tm_next[h] = NIL;
        end
        if (n == 0) wake_expect.push_back(mk_res(0, 0, 0, ST_OK, 1));
        else begin
          w = wake_expect.pop_back();
          w.last = 1;
          wake_expect.push_back(w);
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: hold a request until taken, then advance to the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) predict_wakeups(req);
      if (start && busy) begin
        // hold the current request
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req   <= pending_reqs.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && strobe) begin
      if (wake_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res);
      end else begin
        e = wake_expect.pop_front();
        if (res.woke_valid !== e.woke_valid || res.woke_proc !== e.woke_proc ||
            res.woke_slot !== e.woke_slot || res.status !== e.status ||
            res.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic req_t mk_req(func_t f, int s, logic [31:0] e, logic [11:0] p);
    req_t r;
    r.func = f;
    r.timer_slot = s[3:0];
    r.expires_ticks = e;
    r.proc_id = p;
    return r;
  endfunction

  task automatic add_random(int count);
    int k, sel;
    logic [31:0] e;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9) begin
        e = (sel == 0) ? $urandom() : $urandom_range(1, 8);
        pending_reqs.push_back(mk_req(FN_ADD, $urandom_range(0, NT - 1), e,
                                      $urandom_range(0, 4095)));
      end else if (sel < 12)
        pending_reqs.push_back(mk_req(FN_DEL, $urandom_range(0, NT - 1),
                                      $urandom(), $urandom_range(0, 4095)));
      else if (sel < 19)
        pending_reqs.push_back(mk_req(FN_TICK, $urandom_range(0, NT - 1),
                                      $urandom(), $urandom_range(0, 4095)));
      else
        pending_reqs.push_back(mk_req(FN_NOP, $urandom_range(0, NT - 1),
                                      $urandom(), $urandom_range(0, 4095)));
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start || busy || wake_expect.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int i;
    for (i = 0; i < NT; i++) begin
      tm_active[i] = 0;
      tm_delta[i]  = 0;
      tm_proc[i]   = 0;
      tm_next[i]   = NIL;
    end
    tm_head = NIL;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tick, zero expiry, active and inactive slots,
    // equal expiry ordering, mid-list delete, extremes of the fields.
    no_idle = 1;
    pending_reqs.push_back(mk_req(FN_TICK, 0, 0, 0));
    pending_reqs.push_back(mk_req(FN_ADD, 2, 0, 12'h123));
    pending_reqs.push_back(mk_req(FN_ADD, 0, 5, 12'hFFF));
    pending_reqs.push_back(mk_req(FN_ADD, 0, 3, 12'h001));
    pending_reqs.push_back(mk_req(FN_DEL, 9, 0, 0));
    pending_reqs.push_back(mk_req(FN_ADD, 15, 32'hFFFF_FFFF, 12'h000));
    pending_reqs.push_back(mk_req(FN_ADD, 3, 5, 12'hABC));
    pending_reqs.push_back(mk_req(FN_ADD, 4, 2, 12'h555));
    pending_reqs.push_back(mk_req(FN_ADD, 5, 4, 12'hAAA));
    pending_reqs.push_back(mk_req(FN_DEL, 5, 0, 0));
    pending_reqs.push_back(mk_req(FN_NOP, 15, 32'hFFFF_FFFF, 12'hFFF));
    for (i = 0; i < 6; i++) pending_reqs.push_back(mk_req(FN_TICK, 0, 0, 0));
    pending_reqs.push_back(mk_req(FN_DEL, 15, 0, 0));
    pending_reqs.push_back(mk_req(FN_DEL, 15, 0, 0));
    drain();

    // Fill every slot with the same expiry so one tick wakes all of them.
    no_idle = 0;
    for (i = 0; i < NT; i++)
      pending_reqs.push_back(mk_req(FN_ADD, i, 1, $urandom_range(0, 4095)));
    pending_reqs.push_back(mk_req(FN_TICK, 0, 0, 0));
    drain();

    // Random traffic in four phases; the third runs without gaps.
    for (i = 0; i < 4; i++) begin
      no_idle = (i == 2);
      add_random(16);
      drain();
    end

    if (mismatches == 0 && wake_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
